>>> rtl/afl_pkg.sv
// ============================================================================
// afl_pkg
// Shared types, sizes and command codes of the active fault list table.
// ============================================================================
package afl_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    localparam logic [2:0] CMD_ADD_PLAIN = 3'd0;
    localparam logic [2:0] CMD_ADD_DET   = 3'd1;
    localparam logic [2:0] CMD_REM_PLAIN = 3'd2;
    localparam logic [2:0] CMD_REM_DET   = 3'd3;
    localparam logic [2:0] CMD_SEARCH    = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    typedef struct packed {
        logic [7:0]         sev;
        logic [7:0]         kind;
        logic [7:0]         mdl;
        logic [7:0]         cab;
        logic signed [31:0] val;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic       hit;
        logic       is_new;
        logic       read_ok;
        rec_t       rec;
        logic [4:0] count;
    } res_t;

endpackage

>>> rtl/afl_ram.sv
// ============================================================================
// afl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module afl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/afl_ctrl.sv
// ============================================================================
// afl_ctrl
// Command sequencer: scans the record RAM, closes gaps, appends, reads back.
// ============================================================================
module afl_ctrl (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cmd_valid,
    output logic                         cmd_ready,
    input  logic [2:0]                   cmd_code,
    input  afl_pkg::rec_t                cmd_key,
    input  logic [7:0]                   cmd_index,
    output logic                         res_valid,
    input  logic                         res_ready,
    output afl_pkg::res_t                res,
    output logic                         ram_we,
    output logic [afl_pkg::IDX_W-1:0]    ram_waddr,
    output logic [afl_pkg::REC_W-1:0]    ram_wdata,
    output logic [afl_pkg::IDX_W-1:0]    ram_raddr,
    input  logic [afl_pkg::REC_W-1:0]    ram_rdata
);
    import afl_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_SHIFT = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_RDATA = 3'd4;
    localparam logic [2:0] ST_FIN   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

    logic [2:0]       state_reg, state_next;
    logic [2:0]       cmd_reg, cmd_next;
    rec_t             key_reg, key_next;
    logic [7:0]       idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] cmp_reg, cmp_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    res_t             res_reg, res_next;

    rec_t             rd_rec;
    logic             full_match;
    logic             is_add;
    logic             is_rem;
    logic             match;
    logic             hit_now;
    logic             issue;
    logic             idx_ok;
    logic             cmd_full;
    logic [CNT_W-1:0] c_work;
    logic [CNT_W-1:0] wr_pos;
    logic [CNT_W+4:0] cnt_wide;

    assign rd_rec     = rec_t'(ram_rdata);
    assign full_match = (cmd_reg == CMD_ADD_DET) || (cmd_reg == CMD_REM_DET);
    assign is_add     = (cmd_reg == CMD_ADD_PLAIN) || (cmd_reg == CMD_ADD_DET);
    assign is_rem     = (cmd_reg == CMD_REM_PLAIN) || (cmd_reg == CMD_REM_DET);
    assign cmd_full   = (cmd_code == CMD_ADD_DET) || (cmd_code == CMD_REM_DET);
    assign match      = (rd_rec.sev == key_reg.sev) && (rd_rec.kind == key_reg.kind)
                        && (!full_match || ((rd_rec.mdl == key_reg.mdl)
                        && (rd_rec.cab == key_reg.cab) && (rd_rec.val == key_reg.val)));
    assign hit_now    = pend_reg && match;
    assign idx_ok     = ({{CNT_W{1'b0}}, idx_reg} < {8'd0, count_reg});
    assign c_work     = (found_reg && (is_add || is_rem)) ? (count_reg - 1'b1) : count_reg;
    assign wr_pos     = cmp_reg - 1'b1;
    assign cnt_wide   = {5'd0, count_next};

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        key_next   = key_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        cmp_next   = cmp_reg;
        pend_next  = pend_reg;
        found_next = found_reg;
        res_next   = res_reg;
        issue      = 1'b0;
        cmd_ready  = 1'b0;
        res_valid  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = wr_pos[IDX_W-1:0];
        ram_wdata  = ram_rdata;
        ram_raddr  = ptr_reg[IDX_W-1:0];
        case (state_reg)
            ST_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next     = cmd_code;
                    key_next     = cmd_key;
                    if (!cmd_full) begin
                        key_next.mdl = 8'd0;
                        key_next.cab = 8'd0;
                        key_next.val = 32'sd0;
                    end
                    idx_next   = cmd_index;
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    res_next   = '0;
                    case (cmd_code)
                        CMD_ADD_PLAIN, CMD_ADD_DET, CMD_REM_PLAIN, CMD_REM_DET,
                        CMD_SEARCH: state_next = ST_SCAN;
                        CMD_READ:   state_next = ST_READ;
                        default:    state_next = ST_FIN;
                    endcase
                end
            end
            ST_SCAN: begin
                issue = (ptr_reg < count_reg) && !hit_now;
                if (hit_now) begin
                    found_next = 1'b1;
                    ptr_next   = cmp_reg + 1'b1;
                    pend_next  = 1'b0;
                    state_next = (cmd_reg == CMD_SEARCH) ? ST_FIN : ST_SHIFT;
                end else if (issue) begin
                    ptr_next  = ptr_reg + 1'b1;
                    cmp_next  = ptr_reg;
                    pend_next = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_FIN;
                end
            end
            ST_SHIFT: begin
                issue  = (ptr_reg < count_reg);
                ram_we = pend_reg;
                if (issue) begin
                    ptr_next  = ptr_reg + 1'b1;
                    cmp_next  = ptr_reg;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                    if (!pend_reg) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_READ: begin
                ram_raddr  = idx_reg[IDX_W-1:0];
                state_next = ST_RDATA;
            end
            ST_RDATA: begin
                res_next.read_ok = idx_ok;
                res_next.rec     = idx_ok ? rd_rec : '0;
                state_next       = ST_FIN;
            end
            ST_FIN: begin
                ram_waddr  = c_work[IDX_W-1:0];
                ram_wdata  = key_reg;
                count_next = c_work;
                if (is_add && (c_work < FULL_CNT)) begin
                    ram_we     = 1'b1;
                    count_next = c_work + 1'b1;
                end
                res_next.hit    = found_reg;
                res_next.is_new = is_add && !found_reg;
                res_next.count  = cnt_wide[4:0];
                state_next      = ST_DONE;
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        key_reg <= key_next;
        idx_reg <= idx_next;
        ptr_reg <= ptr_next;
        cmp_reg <= cmp_next;
        res_reg <= res_next;
    end

    assign res = res_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("record count above capacity");

    a_count_only_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_FIN) |=> $stable(count_reg))
        else $error("record count changed outside finish step");

    a_write_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ((state_reg == ST_SHIFT) || (state_reg == ST_FIN)))
        else $error("record write outside shift or finish");

    a_shift_below_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && (state_reg == ST_SHIFT)) |-> (wr_pos < count_reg))
        else $error("shift write beyond live records");

    a_search_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_FIN) && (cmd_reg == CMD_SEARCH)) |=> $stable(count_reg))
        else $error("search changed record count");

endmodule

>>> rtl/active_fault_list_table.sv
// ============================================================================
// active_fault_list_table
// Ordered list of active fault records with add, remove, search and read.
// ============================================================================
// Add, remove and search scan the records once; an add or remove that hits then
// makes one shift pass to close the gap, all through the single record RAM port pair.
// A read gives the record through one registered RAM read.
// Throughput: one command at a time; the next can be taken while a result waits in the output register.
// Reset: record count cleared; record RAM contents are left as they are.
module active_fault_list_table (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_command,
    input  logic [7:0]         s_severity,
    input  logic [7:0]         s_kind,
    input  logic [7:0]         s_module_num,
    input  logic [7:0]         s_cabinet_num,
    input  logic signed [31:0] s_extra_value,
    input  logic [7:0]         s_read_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_hit,
    output logic               m_is_new,
    output logic               m_read_ok,
    output logic [7:0]         m_severity_out,
    output logic [7:0]         m_kind_out,
    output logic [7:0]         m_module_out,
    output logic [7:0]         m_cabinet_out,
    output logic signed [31:0] m_value_out,
    output logic [4:0]         m_entry_count
);
    import afl_pkg::*;

    rec_t             key;
    res_t             res;
    logic             res_valid;
    logic             res_ready;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_raddr;
    logic [REC_W-1:0] ram_wdata;
    logic [REC_W-1:0] ram_rdata;
    logic             out_valid_reg;
    res_t             out_reg;

    assign key.sev  = s_severity;
    assign key.kind = s_kind;
    assign key.mdl  = s_module_num;
    assign key.cab  = s_cabinet_num;
    assign key.val  = s_extra_value;

    afl_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (s_valid),
        .cmd_ready (s_ready),
        .cmd_code  (s_command),
        .cmd_key   (key),
        .cmd_index (s_read_index),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    afl_ram #(
        .WIDTH (REC_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !out_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_hit          = out_reg.hit;
    assign m_is_new       = out_reg.is_new;
    assign m_read_ok      = out_reg.read_ok;
    assign m_severity_out = out_reg.rec.sev;
    assign m_kind_out     = out_reg.rec.kind;
    assign m_module_out   = out_reg.rec.mdl;
    assign m_cabinet_out  = out_reg.rec.cab;
    assign m_value_out    = out_reg.rec.val;
    assign m_entry_count  = out_reg.count;

endmodule
